// File: rtl/chd_pkg.sv
package chd_pkg;

	// Field widths
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned PAIR_W  = PIX_W + 1;
	localparam int unsigned QUAD_W  = PIX_W + 2;
	localparam int unsigned WIDTH_W = 11;
	localparam int unsigned HEIGHT_W = 13;
	localparam int unsigned CFG_W   = 13;

	// Configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Command queue geometry
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = 2;
	localparam int unsigned Q_CW    = 3;

	// One raster pixel
	typedef struct packed {
		logic [PIX_W-1:0] red_diff;
		logic [PIX_W-1:0] blue_diff;
		logic [PIX_W-1:0] luma;
	} pix_t;

	// One 4:2:0 block
	typedef struct packed {
		logic [PIX_W-1:0] luma_top_left;
		logic [PIX_W-1:0] luma_top_right;
		logic [PIX_W-1:0] luma_bottom_left;
		logic [PIX_W-1:0] luma_bottom_right;
		logic [PIX_W-1:0] blue_avg;
		logic [PIX_W-1:0] red_avg;
		logic             last_block;
	} blk_t;

	// Line store word: one pixel pair of the top row
	typedef struct packed {
		logic [PAIR_W-1:0] cr_sum;
		logic [PAIR_W-1:0] cb_sum;
		logic [PIX_W-1:0]  luma_right;
		logic [PIX_W-1:0]  luma_left;
	} entry_t;

	// Front to back command: a finished pixel pair
	typedef struct packed {
		logic   is_write;
		logic   last_block;
		entry_t pair;
	} cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage

// File: rtl/chd_front.sv
module chd_front #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned SLOT_W    = 9
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [chd_pkg::WIDTH_W-1:0]     frame_width,
	input  logic [chd_pkg::HEIGHT_W-1:0]    frame_height,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  chd_pkg::pix_t                   pix,
	input  chd_pkg::q_stat_t                q_stat,
	output logic                            push,
	output chd_pkg::cmd_t                   push_cmd,
	output logic [SLOT_W-1:0]               push_slot
);

	localparam int unsigned STORE_DEPTH = MAX_WIDTH / 2;
	localparam int unsigned W = chd_pkg::WIDTH_W;
	localparam int unsigned H = chd_pkg::HEIGHT_W;

	logic [W-1:0]          col_q;
	logic [H-1:0]          row_q;
	chd_pkg::pix_t         held_q;
	logic [W-1:0]          eff_width;
	logic [W-1:0]          col_lim;
	logic [H-1:0]          row_lim;
	logic                  in_range;
	logic                  accept;
	logic                  row_end;
	logic                  frame_end;
	logic [W-2:0]          pair_col;

	// Width saturates at the line store size
	assign eff_width = (32'(frame_width) > MAX_WIDTH) ? W'(MAX_WIDTH) : frame_width;
	assign col_lim   = {eff_width[W-1:1], 1'b0};
	assign row_lim   = {frame_height[H-1:1], 1'b0};
	assign in_range  = (col_q < col_lim) && (row_q < row_lim);

	assign pix_stall = q_stat.full;
	assign accept    = pix_valid && !q_stat.full;

	assign row_end   = ({1'b0, col_q} + 1'b1) >= {1'b0, eff_width};
	assign frame_end = ({1'b0, row_q} + 1'b1) >= {1'b0, frame_height};

	// Pair column index, clamped to the store
	assign pair_col  = col_q[W-1:1];
	assign push_slot = (32'(pair_col) >= STORE_DEPTH) ? SLOT_W'(STORE_DEPTH - 1)
		: SLOT_W'(pair_col);

	// Odd column closes a pair: even row fills the store, odd row finishes a block
	assign push = accept && in_range && col_q[0];
	always_comb begin
		push_cmd.is_write        = !row_q[0];
		push_cmd.last_block      = (({1'b0, row_q} + 1'b1) == {1'b0, row_lim})
			&& (({1'b0, col_q} + 1'b1) == {1'b0, col_lim});
		push_cmd.pair.luma_left  = held_q.luma;
		push_cmd.pair.luma_right = pix.luma;
		push_cmd.pair.cb_sum     = {1'b0, held_q.blue_diff} + {1'b0, pix.blue_diff};
		push_cmd.pair.cr_sum     = {1'b0, held_q.red_diff} + {1'b0, pix.red_diff};
	end

	// Raster position and even-column hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (in_range && !col_q[0]) begin
				held_q <= pix;
			end
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/chd_queue.sv
module chd_queue #(
	parameter int unsigned SLOT_W = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  chd_pkg::cmd_t        push_cmd,
	input  logic [SLOT_W-1:0]    push_slot,
	input  logic                 pop,
	output chd_pkg::q_stat_t     q_stat,
	output chd_pkg::cmd_t        pop_cmd,
	output logic [SLOT_W-1:0]    pop_slot
);

	chd_pkg::cmd_t             cmd_q  [chd_pkg::Q_DEPTH];
	logic [SLOT_W-1:0]         slot_q [chd_pkg::Q_DEPTH];
	logic [chd_pkg::Q_AW-1:0]  wr_ptr_q;
	logic [chd_pkg::Q_AW-1:0]  rd_ptr_q;
	logic [chd_pkg::Q_CW-1:0]  count_q;

	assign q_stat.valid = (count_q != '0);
	assign q_stat.full  = (count_q == chd_pkg::Q_CW'(chd_pkg::Q_DEPTH));
	assign pop_cmd      = cmd_q[rd_ptr_q];
	assign pop_slot     = slot_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q]  <= push_cmd;
			slot_q[wr_ptr_q] <= push_slot;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/chd_back.sv
module chd_back #(
	parameter int unsigned STORE_DEPTH = 512,
	parameter int unsigned SLOT_W      = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  chd_pkg::q_stat_t     q_stat,
	input  chd_pkg::cmd_t        pop_cmd,
	input  logic [SLOT_W-1:0]    pop_slot,
	output logic                 pop,
	output logic                 blk_valid,
	input  logic                 blk_stall,
	output chd_pkg::blk_t        blk
);

	localparam int unsigned QW = chd_pkg::QUAD_W;

	chd_pkg::entry_t  store_q [STORE_DEPTH];
	chd_pkg::entry_t  top_s2;
	chd_pkg::cmd_t    cmd_s2;
	logic             valid_s2;
	logic             out_valid_q;
	chd_pkg::blk_t    out_q;
	logic             out_ready;
	logic             s2_ready;
	logic             rd_en;
	logic [QW-1:0]    cb_quad;
	logic [QW-1:0]    cr_quad;

	assign out_ready = !out_valid_q || !blk_stall;
	assign s2_ready  = !valid_s2 || out_ready;
	// Store writes retire at once; reads need room in stage two
	assign pop       = q_stat.valid && (pop_cmd.is_write || s2_ready);
	assign rd_en     = pop && !pop_cmd.is_write;

	// Line store, one access per cycle, registered read
	always_ff @(posedge clk) begin
		if (pop && pop_cmd.is_write) begin
			store_q[pop_slot] <= pop_cmd.pair;
		end
		if (rd_en) begin
			top_s2 <= store_q[pop_slot];
			cmd_s2 <= pop_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rd_en) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Four-pixel chroma sums
	assign cb_quad = QW'(top_s2.cb_sum) + QW'(cmd_s2.pair.cb_sum);
	assign cr_quad = QW'(top_s2.cr_sum) + QW'(cmd_s2.pair.cr_sum);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			out_q.luma_top_left     <= top_s2.luma_left;
			out_q.luma_top_right    <= top_s2.luma_right;
			out_q.luma_bottom_left  <= cmd_s2.pair.luma_left;
			out_q.luma_bottom_right <= cmd_s2.pair.luma_right;
			out_q.blue_avg          <= cb_quad[QW-1:2];
			out_q.red_avg           <= cr_quad[QW-1:2];
			out_q.last_block        <= cmd_s2.last_block;
		end
	end

	assign blk_valid = out_valid_q;
	assign blk       = out_q;

endmodule

// File: rtl/chroma_420_downsampler_core.sv
// 4:2:0 chroma subsampler: takes YCbCr pixels in raster order and emits one
// block per 2x2 square (four luma values, truncated Cb and Cr averages),
// flagging the last block of each frame; a trailing odd column or row is
// dropped. Sustained rate is one pixel per clock while the queue is not full:
// the front end counts raster position and pairs pixels, a four-entry command
// queue decouples it from the back end, and the back end makes a single line
// store access per pixel pair. Each block passes the queue, stage two and the
// output register. The line store of MAX_WIDTH/2 pairs needs no clearing.
// Write frame_width and frame_height only while no pixel is in flight.
module chroma_420_downsampler_core #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [chd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  chd_pkg::pix_t                  pix,
	output logic                           blk_valid,
	input  logic                           blk_stall,
	output chd_pkg::blk_t                  blk
);

	localparam int unsigned STORE_DEPTH = MAX_WIDTH / 2;
	localparam int unsigned SLOT_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [chd_pkg::WIDTH_W-1:0]   frame_width_q;
	logic [chd_pkg::HEIGHT_W-1:0]  frame_height_q;
	chd_pkg::q_stat_t              q_stat;
	logic                          push;
	chd_pkg::cmd_t                 push_cmd;
	logic [SLOT_W-1:0]             push_slot;
	logic                          pop;
	chd_pkg::cmd_t                 pop_cmd;
	logic [SLOT_W-1:0]             pop_slot;

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= chd_pkg::WIDTH_W'(100);
			frame_height_q <= chd_pkg::HEIGHT_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				chd_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[chd_pkg::WIDTH_W-1:0];
				chd_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default:                   frame_width_q  <= frame_width_q;
			endcase
		end
	end

	chd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.SLOT_W    (SLOT_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.pix          (pix),
		.q_stat       (q_stat),
		.push         (push),
		.push_cmd     (push_cmd),
		.push_slot    (push_slot)
	);

	chd_queue #(
		.SLOT_W (SLOT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_slot (push_slot),
		.pop       (pop),
		.q_stat    (q_stat),
		.pop_cmd   (pop_cmd),
		.pop_slot  (pop_slot)
	);

	chd_back #(
		.STORE_DEPTH (STORE_DEPTH),
		.SLOT_W      (SLOT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_cmd   (pop_cmd),
		.pop_slot  (pop_slot),
		.pop       (pop),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk       (blk)
	);

`ifndef NO_ASSERTIONS
	// Front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("command pushed into full queue");

	// Back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.valid)
		else $error("command popped from empty queue");

	// A push without a pop leaves the queue occupied
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> q_stat.valid)
		else $error("pushed command lost");
`endif

endmodule

// File: tb/chroma_420_block_checker.sv
// Watches the configuration, pixel and block channels, keeps its own copy of
// the raster position, pair hold and line store, and compares every block the
// core hands out with the oldest predicted one.
module chroma_420_block_checker #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [chd_pkg::CFG_W-1:0] cfg_data,
	input  logic                      pix_valid,
	input  logic                      pix_stall,
	input  chd_pkg::pix_t             pix,
	input  logic                      blk_valid,
	input  logic                      blk_stall,
	input  chd_pkg::blk_t             blk,
	output int                        block_errors = 0,
	output int                        blocks_due = 0
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS        = MAX_WIDTH / 2;
	localparam int unsigned RESET_WIDTH  = 100;
	localparam int unsigned RESET_HEIGHT = 100;

	// register copies and raster state
	logic [chd_pkg::WIDTH_W-1:0]  cur_width;
	logic [chd_pkg::HEIGHT_W-1:0] cur_height;
	chd_pkg::entry_t              line_store [SLOTS];
	chd_pkg::pix_t                held_pix;
	logic [chd_pkg::WIDTH_W-1:0]  raster_col;
	logic [chd_pkg::HEIGHT_W-1:0] raster_row;
	chd_pkg::blk_t                pending_blocks [$];

	// one pixel: hold even column, store top pair, or finish a square
	function automatic void subsample_pixel(input chd_pkg::pix_t p);
		int unsigned     w, h, col_lim, row_lim, slot, cb_sum, cr_sum;
		chd_pkg::entry_t e;
		chd_pkg::blk_t   b;
		w = (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
		h = cur_height;
		col_lim = (w / 2) * 2;
		row_lim = (h / 2) * 2;
		slot = raster_col / 2;
		if (slot >= SLOTS)
			slot = SLOTS - 1;
		if (raster_col < col_lim && raster_row < row_lim) begin
			if (!raster_col[0]) begin
				held_pix = p;
			end else if (!raster_row[0]) begin
				e.luma_left  = held_pix.luma;
				e.luma_right = p.luma;
				e.cb_sum     = held_pix.blue_diff + p.blue_diff;
				e.cr_sum     = held_pix.red_diff + p.red_diff;
				line_store[slot] = e;
			end else begin
				e = line_store[slot];
				cb_sum = e.cb_sum + held_pix.blue_diff + p.blue_diff;
				cr_sum = e.cr_sum + held_pix.red_diff + p.red_diff;
				b.luma_top_left     = e.luma_left;
				b.luma_top_right    = e.luma_right;
				b.luma_bottom_left  = held_pix.luma;
				b.luma_bottom_right = p.luma;
				b.blue_avg          = 8'(cb_sum >> 2);
				b.red_avg           = 8'(cr_sum >> 2);
				b.last_block        = (raster_row + 1 == row_lim) &&
					(raster_col + 1 == col_lim);
				pending_blocks.push_back(b);
			end
		end
		// advance raster position; counters are never cleared by a register write
		if (raster_col + 1 >= w) begin
			raster_col = '0;
			raster_row = (raster_row + 1 >= h) ? '0 : raster_row + 1'b1;
		end else begin
			raster_col = raster_col + 1'b1;
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			block_errors++;
		end
	endfunction

	// sample at the falling edge: inputs only move at the rising edge
	always @(negedge clk) begin
		chd_pkg::blk_t want;
		if (!arst_n) begin
			cur_width  = chd_pkg::WIDTH_W'(RESET_WIDTH);
			cur_height = chd_pkg::HEIGHT_W'(RESET_HEIGHT);
			held_pix   = '0;
			raster_col = '0;
			raster_row = '0;
			pending_blocks.delete();
			block_errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == chd_pkg::REG_FRAME_WIDTH)
					cur_width = cfg_data[chd_pkg::WIDTH_W-1:0];
				else
					cur_height = cfg_data[chd_pkg::HEIGHT_W-1:0];
			end
			if (pix_valid && !pix_stall)
				subsample_pixel(pix);
			if (blk_valid && !blk_stall) begin
				if (pending_blocks.size() == 0) begin
					$display("%0t: block with none predicted, got %h", $time, blk);
					block_errors++;
				end else begin
					want = pending_blocks.pop_front();
					check_field("luma_top_left", want.luma_top_left, blk.luma_top_left);
					check_field("luma_top_right", want.luma_top_right, blk.luma_top_right);
					check_field("luma_bottom_left", want.luma_bottom_left,
						blk.luma_bottom_left);
					check_field("luma_bottom_right", want.luma_bottom_right,
						blk.luma_bottom_right);
					check_field("blue_avg", want.blue_avg, blk.blue_avg);
					check_field("red_avg", want.red_avg, blk.red_avg);
					check_field("last_block", {7'd0, want.last_block},
						{7'd0, blk.last_block});
				end
			end
		end
		blocks_due = pending_blocks.size();
	end

endmodule

// File: tb/tb_chroma_420_downsampler_core.sv
module tb_chroma_420_downsampler_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_W        = 1024;
	localparam int          RESET_CYCLES = 7;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          QUIET_LIMIT  = 2000;
	localparam int          RANDOM_ITEMS = 350;
	localparam int          SECOND_ROW   = 128;

	logic                         clk;
	logic                         arst_n    = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic                         cfg_index = chd_pkg::REG_FRAME_WIDTH;
	logic [chd_pkg::CFG_W-1:0]    cfg_data  = '0;
	logic                         pix_valid = 1'b0;
	logic                         pix_stall;
	chd_pkg::pix_t                pix       = '0;
	logic                         blk_valid;
	logic                         blk_stall = 1'b0;
	chd_pkg::blk_t                blk;
	int                           block_errors;
	int                           blocks_due;
	int                           burst_left = 0;
	int                           hold_req   = 0;
	int                           hold_done  = 0;

	chroma_420_downsampler_core #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.blk_valid(blk_valid),
		.blk_stall(blk_stall),
		.blk(blk)
	);

	chroma_420_block_checker #(
		.MAX_WIDTH(MAX_W)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.blk_valid(blk_valid),
		.blk_stall(blk_stall),
		.blk(blk),
		.block_errors(block_errors),
		.blocks_due(blocks_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic chd_pkg::pix_t mk(input logic [7:0] y, input logic [7:0] cb,
			input logic [7:0] cr);
		return {cr, cb, y};
	endfunction

	// mostly uniform, with all-ones and all-zeros pixels mixed in
	function automatic chd_pkg::pix_t random_pixel();
		logic [31:0]   r;
		chd_pkg::pix_t p;
		r = $urandom;
		p = r[23:0];
		if (r[31:30] == 2'b00)
			p = r[29] ? '1 : '0;
		return p;
	endfunction

	// both registers back to back; upper data bits are don't-care for width
	task automatic write_frame(input logic [chd_pkg::WIDTH_W-1:0] w,
			input logic [chd_pkg::HEIGHT_W-1:0] h);
		logic [31:0] r;
		r = $urandom;
		cfg_valid <= 1'b1;
		cfg_index <= chd_pkg::REG_FRAME_WIDTH;
		cfg_data  <= {r[chd_pkg::CFG_W-chd_pkg::WIDTH_W-1:0], w};
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		cfg_index <= chd_pkg::REG_FRAME_HEIGHT;
		cfg_data  <= h;
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one item; bursts of random length separated by random gaps
	task automatic send_pixel(input chd_pkg::pix_t p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 24);
			if (gap > 0) begin
				pix_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pix       <= p;
		pix_valid <= 1'b1;
		do @(negedge clk); while (pix_stall !== 1'b0);
		@(posedge clk);
	endtask

	// stop sending and wait for every predicted block, then let the pipe empty
	task automatic drain();
		pix_valid <= 1'b0;
		burst_left = 0;
		while (blocks_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// block output side: stall modes of random length, plus requested long holds
	initial begin
		int mode, left;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				blk_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 160);
			end
			left--;
			case (mode)
				0: blk_stall <= 1'b0;
				1: blk_stall <= ($urandom_range(0, 3) == 0);
				2: blk_stall <= ($urandom_range(0, 3) != 0);
				default: blk_stall <= ((left >> 2) & 1) != 0;
			endcase
		end
	end

	// watchdog: too long without any item moving on any channel
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(negedge clk);
			if ((pix_valid && !pix_stall) || (blk_valid && !blk_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int unsigned w, h, n;
		int          sent_random;
		int          phase;
		sent_random = 0;
		phase = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2 frames: saturated sums, all zero, then truncating averages
		write_frame(11'd2, 13'd2);
		repeat (4) send_pixel(mk(8'hFF, 8'hFF, 8'hFF));
		repeat (4) send_pixel(mk(8'h00, 8'h00, 8'h00));
		send_pixel(mk(8'h55, 8'h01, 8'hFF));
		send_pixel(mk(8'hAA, 8'h01, 8'hFF));
		send_pixel(mk(8'h0F, 8'h01, 8'hFF));
		send_pixel(mk(8'hF0, 8'h00, 8'hFE));
		drain();

		// odd width and height: trailing column and row are dropped
		write_frame(11'd3, 13'd3);
		repeat (9) send_pixel(random_pixel());
		drain();

		// width below two, then zero width and height, then height below two
		write_frame(11'd1, 13'd5);
		repeat (2) send_pixel(random_pixel());
		drain();
		write_frame(11'd0, 13'd0);
		send_pixel(random_pixel());
		drain();
		write_frame(11'd4, 13'd1);
		repeat (4) send_pixel(random_pixel());
		drain();

		// width above the maximum saturates; the first row fills every line store
		// slot, then the output side holds off during the second row and the core
		// backs up
		write_frame(11'd2047, 13'd2);
		repeat (MAX_W) send_pixel(random_pixel());
		hold_req <= hold_req + 1;
		repeat (SECOND_ROW) send_pixel(random_pixel());
		drain();

		// random geometry; partial runs leave the raster mid-frame on purpose
		while (sent_random < RANDOM_ITEMS) begin
			phase++;
			case ($urandom_range(0, 9))
				0: w = $urandom_range(0, 1);
				1: w = MAX_W;
				2: w = $urandom_range(MAX_W + 1, 2047);
				3: w = $urandom_range(17, 200);
				default: w = $urandom_range(2, 16);
			endcase
			case ($urandom_range(0, 9))
				0: h = $urandom_range(0, 1);
				1: h = 8191;
				2: h = $urandom_range(7, 4096);
				default: h = $urandom_range(2, 6);
			endcase
			if (w <= 16 && h <= 6 && $urandom_range(0, 3) != 0)
				n = w * h * $urandom_range(1, 3);
			else
				n = $urandom_range(20, 300);
			write_frame(chd_pkg::WIDTH_W'(w), chd_pkg::HEIGHT_W'(h));
			if (phase == 2)
				hold_req <= hold_req + 1;
			repeat (n) send_pixel(random_pixel());
			drain();
			sent_random += n;
		end

		if (block_errors == 0 && blocks_due == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
rtl/chd_pkg.sv
rtl/chd_front.sv
rtl/chd_queue.sv
rtl/chd_back.sv
rtl/chroma_420_downsampler_core.sv
tb/chroma_420_block_checker.sv
tb/tb_chroma_420_downsampler_core.sv
